/* design/ctb_pkg.sv */
// shared types, codes and field widths for the countdown timer bank
package ctb_pkg;

    // parameter defaults
    localparam int NUM_TIMERS_DEF  = 8;
    localparam int COUNT_WIDTH_DEF = 32;

    // item field widths
    localparam int MODE_W   = 3;
    localparam int TICKS_W  = 32;
    localparam int TGT_W    = 3;
    localparam int TVAL_W   = 32;
    localparam int KIND_W   = 2;
    localparam int WHICH_W  = 3;
    localparam int TCOUNT_W = 32;

    // stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_START  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STOP   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RELOAD = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SET    = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_STARTED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_EMIT,
        ST_RESULT
    } ctb_state_t;

    typedef struct packed {
        logic capture;
        logic tick_begin;
        logic reload_rd;
        logic scan_step;
        logic finish_single;
        logic emit_tick;
    } ctb_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              out_free;
        logic              scan_done;
        logic              emit_last;
    } ctb_status_t;

endpackage

/* design/ctb_ctrl.sv */
// controller state machine for the countdown timer bank
module ctb_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ctb_pkg::ctb_status_t status,
    output ctb_pkg::ctb_cmd_t    cmd
);

    ctb_pkg::ctb_state_t state_reg;
    ctb_pkg::ctb_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ctb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ctb_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = ctb_pkg::ST_DECODE;
                end
            end
            ctb_pkg::ST_DECODE: begin
                if (status.mode == ctb_pkg::MODE_TICK) begin
                    state_next = ctb_pkg::ST_SCAN;
                end else begin
                    state_next = ctb_pkg::ST_RESULT;
                end
            end
            ctb_pkg::ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = ctb_pkg::ST_EMIT;
                end
            end
            ctb_pkg::ST_EMIT: begin
                if (status.out_free && status.emit_last) begin
                    state_next = ctb_pkg::ST_IDLE;
                end
            end
            ctb_pkg::ST_RESULT: begin
                if (status.out_free) begin
                    state_next = ctb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ctb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ctb_pkg::ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ctb_pkg::ST_DECODE: begin
                cmd.tick_begin = (status.mode == ctb_pkg::MODE_TICK);
                cmd.reload_rd  = (status.mode == ctb_pkg::MODE_RELOAD);
            end
            ctb_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            ctb_pkg::ST_EMIT: begin
                cmd.emit_tick = status.out_free;
            end
            ctb_pkg::ST_RESULT: begin
                cmd.finish_single = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* design/ctb_datapath.sv */
// slot memories, busy bits, tick counter, expiry mask and result register
module ctb_datapath #(
    parameter int NUM_TIMERS  = ctb_pkg::NUM_TIMERS_DEF,
    parameter int COUNT_WIDTH = ctb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ctb_pkg::ctb_cmd_t             cmd,
    output ctb_pkg::ctb_status_t          status,
    input  logic [ctb_pkg::MODE_W-1:0]    in_mode,
    input  logic [ctb_pkg::TICKS_W-1:0]   in_start_ticks,
    input  logic                          in_continuous,
    input  logic [ctb_pkg::TGT_W-1:0]     in_target_timer,
    input  logic [ctb_pkg::TVAL_W-1:0]    in_tick_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ctb_pkg::KIND_W-1:0]    out_kind,
    output logic [ctb_pkg::WHICH_W-1:0]   out_which_timer,
    output logic [ctb_pkg::TCOUNT_W-1:0]  out_tick_count,
    output logic                          out_last
);

    localparam int N     = NUM_TIMERS;
    localparam int CW    = COUNT_WIDTH;
    localparam int IDX_W = (N > 1) ? $clog2(N) : 1;

    // captured item
    logic [ctb_pkg::MODE_W-1:0] mode_reg;
    logic [CW-1:0]              ticks_reg;
    logic                       cont_reg;
    logic [ctb_pkg::TGT_W-1:0]  tgt_reg;
    logic [CW-1:0]              tval_reg;

    // slot state
    logic [N-1:0]  busy_reg,    busy_next;
    logic [N-1:0]  repeats_reg, repeats_next;
    logic [CW-1:0] cnt_mem [N];
    logic [CW-1:0] rel_mem [N];
    logic [CW-1:0] cnt_rd_reg;
    logic [CW-1:0] rel_rd_reg;
    logic [CW-1:0] tick_reg,    tick_next;

    // scan and expiry bookkeeping
    logic [IDX_W-1:0] idx_reg,  idx_next;
    logic [N-1:0]     mask_reg, mask_next;

    // result register
    logic                          m_valid_reg, m_valid_next;
    logic [ctb_pkg::KIND_W-1:0]    m_kind_reg,  m_kind_next;
    logic [ctb_pkg::WHICH_W-1:0]   m_which_reg, m_which_next;
    logic [ctb_pkg::TCOUNT_W-1:0]  m_tick_reg,  m_tick_next;
    logic                          m_last_reg,  m_last_next;

    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             low_found;
    logic [IDX_W-1:0] low_idx;
    logic [N-1:0]     mask_rest;
    logic             tgt_ok;
    logic [IDX_W-1:0] tgt_idx;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [CW-1:0]    cnt_dec;
    logic             expire;
    logic             do_start;
    logic             cnt_we;
    logic [IDX_W-1:0] cnt_waddr;
    logic [CW-1:0]    cnt_wdata;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= in_mode;
            ticks_reg <= CW'(in_start_ticks);
            cont_reg  <= in_continuous;
            tgt_reg   <= in_target_timer;
            tval_reg  <= CW'(in_tick_value);
        end
    end

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // lowest pending expiry
    always_comb begin
        low_found = 1'b0;
        low_idx   = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                low_found = 1'b1;
                low_idx   = IDX_W'(i);
            end
        end
        mask_rest = mask_reg;
        if (low_found) begin
            mask_rest[low_idx] = 1'b0;
        end
    end

    assign tgt_ok   = (8'(tgt_reg) < 8'(N));
    assign tgt_idx  = IDX_W'(tgt_reg);
    assign do_start = cmd.finish_single && (mode_reg == ctb_pkg::MODE_START) && free_found;

    assign rd_en = cmd.tick_begin || cmd.scan_step || cmd.reload_rd;
    always_comb begin
        if (cmd.tick_begin) begin
            rd_addr = '0;
        end else if (cmd.scan_step) begin
            rd_addr = idx_reg + IDX_W'(1);
        end else if (cmd.reload_rd) begin
            rd_addr = tgt_idx;
        end else begin
            rd_addr = idx_reg;
        end
    end

    assign cnt_dec = (cnt_rd_reg != '0) ? (cnt_rd_reg - CW'(1)) : '0;
    assign expire  = busy_reg[idx_reg] && (cnt_dec == '0);

    // count memory write port
    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = idx_reg;
        cnt_wdata = cnt_dec;
        if (do_start) begin
            cnt_we    = 1'b1;
            cnt_waddr = free_idx;
            cnt_wdata = ticks_reg;
        end else if (cmd.finish_single && (mode_reg == ctb_pkg::MODE_RELOAD) && tgt_ok) begin
            cnt_we    = 1'b1;
            cnt_waddr = tgt_idx;
            cnt_wdata = rel_rd_reg;
        end else if (cmd.scan_step && busy_reg[idx_reg]) begin
            cnt_we    = 1'b1;
            cnt_waddr = idx_reg;
            cnt_wdata = (expire && repeats_reg[idx_reg]) ? rel_rd_reg : cnt_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (do_start) begin
            rel_mem[free_idx] <= ticks_reg;
        end
        if (rd_en) begin
            cnt_rd_reg <= cnt_mem[rd_addr];
            rel_rd_reg <= rel_mem[rd_addr];
        end
    end

    always_comb begin
        busy_next    = busy_reg;
        repeats_next = repeats_reg;
        tick_next    = tick_reg;
        idx_next     = idx_reg;
        mask_next    = mask_reg;
        if (do_start) begin
            busy_next[free_idx]    = 1'b1;
            repeats_next[free_idx] = cont_reg;
        end
        if (cmd.finish_single && (mode_reg == ctb_pkg::MODE_STOP) && tgt_ok) begin
            busy_next[tgt_idx] = 1'b0;
        end
        if (cmd.finish_single && (mode_reg == ctb_pkg::MODE_SET)) begin
            tick_next = tval_reg;
        end
        if (cmd.tick_begin) begin
            tick_next = tick_reg + CW'(1);
            idx_next  = '0;
            mask_next = '0;
        end
        if (cmd.scan_step) begin
            idx_next = idx_reg + IDX_W'(1);
            if (expire) begin
                mask_next[idx_reg] = 1'b1;
                if (!repeats_reg[idx_reg]) begin
                    busy_next[idx_reg] = 1'b0;
                end
            end
        end
        if (cmd.emit_tick) begin
            mask_next = mask_rest;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_which_next = m_which_reg;
        m_tick_next  = m_tick_reg;
        m_last_next  = m_last_reg;
        if (cmd.emit_tick) begin
            m_valid_next = 1'b1;
            m_kind_next  = low_found ? ctb_pkg::KIND_EXPIRED : ctb_pkg::KIND_ACK;
            m_which_next = low_found ? ctb_pkg::WHICH_W'(low_idx) : '0;
            m_tick_next  = ctb_pkg::TCOUNT_W'(tick_reg);
            m_last_next  = (mask_rest == '0);
        end else if (cmd.finish_single) begin
            m_valid_next = 1'b1;
            m_kind_next  = ctb_pkg::KIND_ACK;
            m_which_next = '0;
            m_tick_next  = ctb_pkg::TCOUNT_W'(tick_reg);
            m_last_next  = 1'b1;
            case (mode_reg)
                ctb_pkg::MODE_START: begin
                    m_kind_next  = free_found ? ctb_pkg::KIND_STARTED : ctb_pkg::KIND_FULL;
                    m_which_next = free_found ? ctb_pkg::WHICH_W'(free_idx) : '0;
                end
                ctb_pkg::MODE_SET: begin
                    m_tick_next = ctb_pkg::TCOUNT_W'(tval_reg);
                end
                default: begin
                    m_kind_next = ctb_pkg::KIND_ACK;
                end
            endcase
        end else if (out_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= '0;
            repeats_reg <= '0;
            tick_reg    <= '0;
            idx_reg     <= '0;
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            repeats_reg <= repeats_next;
            tick_reg    <= tick_next;
            idx_reg     <= idx_next;
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_kind_reg  <= m_kind_next;
        m_which_reg <= m_which_next;
        m_tick_reg  <= m_tick_next;
        m_last_reg  <= m_last_next;
    end

    assign status.mode      = mode_reg;
    assign status.out_free  = !m_valid_reg || out_ready;
    assign status.scan_done = (idx_reg == IDX_W'(N - 1));
    assign status.emit_last = (mask_rest == '0);

    assign out_valid       = m_valid_reg;
    assign out_kind        = m_kind_reg;
    assign out_which_timer = m_which_reg;
    assign out_tick_count  = m_tick_reg;
    assign out_last        = m_last_reg;

endmodule

/* design/countdown_timer_bank.sv */
// top level of the countdown timer bank
//
// channel   dir  tdata                                          tuser      tlast
// s_axis    in   start_ticks, continuous, target_timer,         mode       -
//                tick_value
// m_axis    out  which_timer, tick_count                        kind       last
//
// sequence: start, stop, reload, set and unknown codes go through accept, decode and result;
// a tick goes through accept, decode and a scan of the slots, one slot per cycle through the
// memories, and then emits its results one at a time on the output register as it frees
// reset: clears busy bits, tick counter and result valid; slot memories are written on start
// stalls: a low m_axis_tready holds the sequencer at its result stage; the next item is
// taken while the last result of the previous one still waits
module countdown_timer_bank #(
    parameter int NUM_TIMERS  = ctb_pkg::NUM_TIMERS_DEF,
    parameter int COUNT_WIDTH = ctb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // start_ticks[31:0], continuous[32], target_timer[35:33], tick_value[67:36]
    input  logic [ctb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // mode[2:0]
    input  logic [ctb_pkg::MODE_W-1:0]      s_axis_tuser,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // which_timer[2:0], tick_count[34:3]
    output logic [ctb_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // kind[1:0]
    output logic [ctb_pkg::KIND_W-1:0]      m_axis_tuser,
    output logic                            m_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready
);

    ctb_pkg::ctb_cmd_t    cmd;
    ctb_pkg::ctb_status_t status;

    // unpacked input item fields
    logic [ctb_pkg::TICKS_W-1:0] in_start_ticks;
    logic                        in_continuous;
    logic [ctb_pkg::TGT_W-1:0]   in_target_timer;
    logic [ctb_pkg::TVAL_W-1:0]  in_tick_value;

    assign in_start_ticks  = s_axis_tdata[31:0];
    assign in_continuous   = s_axis_tdata[32];
    assign in_target_timer = s_axis_tdata[35:33];
    assign in_tick_value   = s_axis_tdata[67:36];

    // result item fields
    logic [ctb_pkg::WHICH_W-1:0]  out_which_timer;
    logic [ctb_pkg::TCOUNT_W-1:0] out_tick_count;

    assign m_axis_tdata = {5'b0, out_tick_count, out_which_timer};

    // sequencer: accept, decode, scan slots, emit results
    ctb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // slot storage and result register
    ctb_datapath #(
        .NUM_TIMERS  (NUM_TIMERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .in_mode         (s_axis_tuser),
        .in_start_ticks  (in_start_ticks),
        .in_continuous   (in_continuous),
        .in_target_timer (in_target_timer),
        .in_tick_value   (in_tick_value),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_kind        (m_axis_tuser),
        .out_which_timer (out_which_timer),
        .out_tick_count  (out_tick_count),
        .out_last        (m_axis_tlast)
    );

endmodule

/* design/ctb_checker.sv */
// port-level assertions for the countdown timer bank, bound to the top level
module ctb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [ctb_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [ctb_pkg::KIND_W-1:0]    m_axis_tuser,
    input logic                          m_axis_tlast
);

    logic                         s_acc;
    logic                         m_acc;
    logic [1:0]                   open_reg,  open_next;
    logic                         run_reg,   run_next;
    logic [ctb_pkg::WHICH_W-1:0]  which_reg, which_next;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    // items accepted whose final result has not gone out yet
    always_comb begin
        open_next  = open_reg + {1'b0, s_acc} - {1'b0, m_acc && m_axis_tlast};
        run_next   = run_reg;
        which_next = which_reg;
        if (m_acc) begin
            run_next   = (m_axis_tuser == ctb_pkg::KIND_EXPIRED) && !m_axis_tlast;
            which_next = m_axis_tdata[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg  <= '0;
            run_reg   <= 1'b0;
            which_reg <= '0;
        end else begin
            open_reg  <= open_next;
            run_reg   <= run_next;
            which_reg <= which_next;
        end
    end

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result valid dropped while stalled");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == ctb_pkg::KIND_STARTED ||
                          m_axis_tuser == ctb_pkg::KIND_FULL ||
                          m_axis_tuser == ctb_pkg::KIND_ACK) |-> m_axis_tlast)
        else $error("single result without last");

    a_one_open: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |-> open_reg <= 2'd1)
        else $error("item accepted with two items still open");

    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        m_acc |-> open_reg != 2'd0)
        else $error("result with no open item");

    a_expiry_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_acc && run_reg && (m_axis_tuser == ctb_pkg::KIND_EXPIRED)
            |-> m_axis_tdata[2:0] > which_reg)
        else $error("expiry results out of slot order");

endmodule

bind countdown_timer_bank ctb_checker u_ctb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

/* test/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for the countdown timer bank: directed cases, then random traffic
module testbench;
    import ctb_pkg::*;

    localparam int NT = NUM_TIMERS_DEF;
    // modes 5 to 7 carry no operation and must only be acknowledged
    localparam logic [MODE_W-1:0] MODE_FIRST_UNUSED = 3'd5;
    // idle cycles with no handshake on either side before the run is declared hung
    localparam int HANG_LIMIT = 3000;
    // settle time after a drain, with margin over a full tick scan plus eight expiries
    localparam int SETTLE_CYCLES = 30;
    // length of the long result hold-off that backs the block up
    localparam int HOLD_CYCLES = 300;

    // one input item as the block sees it
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [TICKS_W-1:0] ticks;
        logic               cont;
        logic [TGT_W-1:0]   tgt;
        logic [TVAL_W-1:0]  tval;
    } timer_op_t;

    // one result item
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [WHICH_W-1:0]  which;
        logic [TCOUNT_W-1:0] tcount;
        logic                last;
    } timer_event_t;

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [MODE_W-1:0]     s_axis_tuser  = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;

    // shadow copy of the timer bank, updated as each item is accepted
    logic                slot_active   [NT];
    logic [TICKS_W-1:0]  slot_left     [NT];
    logic [TICKS_W-1:0]  slot_period   [NT];
    logic                slot_periodic [NT];
    logic [TCOUNT_W-1:0] tick_now;

    timer_event_t expected_events[$];
    int           mismatches = 0;
    int           idle_cycles = 0;
    bit           no_idle = 1'b0;   // both sides run back to back while set
    int           hold_len = 0;     // receiver holds tready low this long when set

    countdown_timer_bank i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // work out the results one accepted item causes and queue them in order
    task automatic predict_timer_events(input timer_op_t op);
        timer_event_t evs[$];
        int free_slot;
        free_slot = -1;
        case (op.mode)
            MODE_TICK: begin
                tick_now = tick_now + 1'b1;
                // busy slots count down in ascending order, expiries come out the same way
                for (int i = 0; i < NT; i++) begin
                    if (slot_active[i]) begin
                        if (slot_left[i] != '0) slot_left[i] = slot_left[i] - 1'b1;
                        if (slot_left[i] == '0) begin
                            if (slot_periodic[i]) slot_left[i] = slot_period[i];
                            else slot_active[i] = 1'b0;
                            evs.push_back('{KIND_EXPIRED, WHICH_W'(i), tick_now, 1'b0});
                        end
                    end
                end
                // a quiet tick is still acknowledged
                if (evs.size() == 0) evs.push_back('{KIND_ACK, '0, tick_now, 1'b0});
            end
            MODE_START: begin
                for (int i = NT - 1; i >= 0; i--) begin
                    if (!slot_active[i]) free_slot = i;
                end
                if (free_slot < 0) begin
                    // bank full leaves every slot as it was
                    evs.push_back('{KIND_FULL, '0, tick_now, 1'b0});
                end else begin
                    slot_active[free_slot]   = 1'b1;
                    slot_left[free_slot]     = op.ticks;
                    slot_period[free_slot]   = op.ticks;
                    slot_periodic[free_slot] = op.cont;
                    evs.push_back('{KIND_STARTED, WHICH_W'(free_slot), tick_now, 1'b0});
                end
            end
            MODE_STOP: begin
                if (int'(op.tgt) < NT) slot_active[op.tgt] = 1'b0;
                evs.push_back('{KIND_ACK, '0, tick_now, 1'b0});
            end
            MODE_RELOAD: begin
                // restores the count even on a free slot
                if (int'(op.tgt) < NT) slot_left[op.tgt] = slot_period[op.tgt];
                evs.push_back('{KIND_ACK, '0, tick_now, 1'b0});
            end
            MODE_SET: begin
                tick_now = op.tval;
                evs.push_back('{KIND_ACK, '0, tick_now, 1'b0});
            end
            default: begin
                evs.push_back('{KIND_ACK, '0, tick_now, 1'b0});
            end
        endcase
        evs[evs.size() - 1].last = 1'b1;
        foreach (evs[k]) expected_events.push_back(evs[k]);
    endtask

    // offer one item after a random gap and wait until the block takes it;
    // tvalid stays high on a zero gap so back-to-back items need no second assignment
    task automatic send_op(input timer_op_t op);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tdata  <= {{(S_TDATA_W - 68){1'b0}}, op.tval, op.tgt, op.cont, op.ticks};
        s_axis_tuser  <= op.mode;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        predict_timer_events(op);
    endtask

    function automatic timer_op_t op_of(input logic [MODE_W-1:0] mode,
                                        input logic [TICKS_W-1:0] ticks,
                                        input logic cont,
                                        input logic [TGT_W-1:0] tgt,
                                        input logic [TVAL_W-1:0] tval);
        timer_op_t op;
        op.mode  = mode;
        op.ticks = ticks;
        op.cont  = cont;
        op.tgt   = tgt;
        op.tval  = tval;
        return op;
    endfunction

    // random item: ticks dominate so timers actually expire, counts mostly short;
    // fields the mode ignores still carry random bits
    function automatic timer_op_t random_op();
        timer_op_t op;
        int pick;
        int span;
        pick = $urandom_range(0, 99);
        if (pick < 40)      op.mode = MODE_TICK;
        else if (pick < 65) op.mode = MODE_START;
        else if (pick < 77) op.mode = MODE_STOP;
        else if (pick < 87) op.mode = MODE_RELOAD;
        else if (pick < 93) op.mode = MODE_SET;
        else                op.mode = MODE_FIRST_UNUSED + MODE_W'($urandom_range(0, 2));
        span = $urandom_range(0, 9);
        if (span < 7)       op.ticks = TICKS_W'($urandom_range(0, 6));
        else if (span < 9)  op.ticks = $urandom;
        else                op.ticks = '1 - TICKS_W'($urandom_range(0, 3));
        op.cont = 1'($urandom_range(0, 1));
        op.tgt  = TGT_W'($urandom_range(0, NT - 1));
        // half the set values land just below the wrap point
        op.tval = $urandom_range(0, 1) ? TVAL_W'($urandom) : '1 - TVAL_W'($urandom_range(0, 4));
        return op;
    endfunction

    // stop offering items until every expected result is in, then let the block settle
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // unused mode codes on an empty bank
    task automatic test_unused_modes();
        for (int k = 0; k < 3; k++) begin
            send_op(op_of(MODE_FIRST_UNUSED + MODE_W'(k), '1, 1'b1, '1, '1));
        end
    endtask

    // set near the top, a quiet tick wraps the counter to zero
    task automatic test_tick_wrap();
        send_op(op_of(MODE_SET, '0, 1'b0, '0, 32'hFFFF_FFFF));
        send_op(op_of(MODE_TICK, '1, 1'b1, '1, '0));
        send_op(op_of(MODE_SET, '0, 1'b0, '0, 32'h0000_0007));
    endtask

    // eight starts of mixed counts and types, then one more finds the bank full
    task automatic test_fill_bank();
        send_op(op_of(MODE_START, 32'd0, 1'b0, '0, '0));          // zero count, one-shot
        send_op(op_of(MODE_START, 32'd1, 1'b1, '0, '0));
        send_op(op_of(MODE_START, 32'd0, 1'b1, '0, '0));          // fires on every tick
        send_op(op_of(MODE_START, 32'hFFFF_FFFF, 1'b0, '0, '0));  // largest count
        send_op(op_of(MODE_START, 32'd2, 1'b1, '1, '1));
        send_op(op_of(MODE_START, 32'd3, 1'b0, '0, '0));
        send_op(op_of(MODE_START, 32'd5, 1'b1, '0, '0));
        send_op(op_of(MODE_START, 32'd4, 1'b0, '0, '0));
        send_op(op_of(MODE_START, 32'd9, 1'b1, '0, '0));
    endtask

    // a few ticks with several expiries each, continuous slots reloading
    task automatic test_tick_expiry();
        repeat (3) send_op(op_of(MODE_TICK, '0, 1'b0, '0, '0));
    endtask

    // stop and reload of busy and free slots, then a start reuses the lowest free slot
    task automatic test_stop_reload();
        send_op(op_of(MODE_STOP, '0, 1'b0, 3'd2, '0));
        send_op(op_of(MODE_STOP, '0, 1'b0, 3'd7, '0));
        send_op(op_of(MODE_RELOAD, '0, 1'b0, 3'd4, '0));
        send_op(op_of(MODE_RELOAD, '0, 1'b0, 3'd0, '0));   // slot freed by its expiry
        send_op(op_of(MODE_RELOAD, '0, 1'b0, 3'd2, '0));   // slot just stopped
        send_op(op_of(MODE_START, 32'd1, 1'b0, '0, '0));
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_output_hold();
        hold_len = HOLD_CYCLES;
        repeat (20) send_op(random_op());
        wait_for_drain();
    endtask

    // random traffic with both sides idling at random
    task automatic test_random_traffic(input int count);
        repeat (count) send_op(random_op());
    endtask

    // back-to-back stretch with no idling on either side
    task automatic test_no_idle_burst(input int count);
        no_idle = 1'b1;
        repeat (count) send_op(random_op());
        no_idle = 1'b0;
    endtask

    // result receiver: random stall per item, a long hold-off on request
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if (hold_len > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid && hold_len == 0);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        timer_event_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_events.size() == 0) begin
                $error("result with nothing expected: kind %0d which_timer %0d",
                       m_axis_tuser, m_axis_tdata[2:0]);
                mismatches++;
            end else begin
                want = expected_events.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata[2:0] !== want.which) begin
                    $error("which_timer: expected %0d, got %0d", want.which, m_axis_tdata[2:0]);
                    mismatches++;
                end
                if (m_axis_tdata[34:3] !== want.tcount) begin
                    $error("tick_count: expected %0h, got %0h", want.tcount, m_axis_tdata[34:3]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // hang detection: too long without a handshake on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // shadow bank starts in its reset state
        for (int i = 0; i < NT; i++) begin
            slot_active[i]   = 1'b0;
            slot_left[i]     = '0;
            slot_period[i]   = '0;
            slot_periodic[i] = 1'b0;
        end
        tick_now = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unused_modes();
        test_tick_wrap();
        test_fill_bank();
        test_tick_expiry();
        test_stop_reload();
        test_output_hold();
        test_random_traffic(200);
        // sender pauses until every result is back
        wait_for_drain();
        test_no_idle_burst(60);
        test_random_traffic(240);
        wait_for_drain();

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
